// ----- hdl/marker_delimited_stream_extractor_unit_assert.svh -----
// Assertion macros used by the deframer top level.
`ifndef MARKER_DELIMITED_STREAM_EXTRACTOR_UNIT_ASSERT_SVH
`define MARKER_DELIMITED_STREAM_EXTRACTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MDSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, checked out of reset.
`define MDSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ----- hdl/mdse_pkg.sv -----
package mdse_pkg;

    localparam int MARKER_LEN = 8;
    localparam int MARKER_W   = 64;
    localparam int IDX_W      = (MARKER_LEN > 1) ? $clog2(MARKER_LEN) : 1;
    localparam int ML_W       = 4;

    localparam logic [MARKER_W-1:0] START_RST = 64'h6162616463616665;
    localparam logic [MARKER_W-1:0] CLOSE_RST = 64'h6162616463306465;

    // Register indexes of the configuration port.
    localparam logic REG_START = 1'b0;
    localparam logic REG_CLOSE = 1'b1;

    // What follows the flushed prefix of one input byte.
    typedef enum logic [1:0] {
        TAIL_NONE = 2'b00,
        TAIL_BYTE = 2'b01,
        TAIL_FEND = 2'b10
    } t_tail;

    typedef struct packed {
        logic latch;  // capture the input beat
        logic eval;   // run the marker compare, update match state
        logic load;   // push the next result into the output register
    } t_cmd;

    typedef struct packed {
        logic any;      // evaluated byte yields at least one result
        logic out_free; // output register can take a result this cycle
        logic last;     // result about to be loaded is the final one
    } t_status;

    // Byte idx of a marker, first byte in the most significant position.
    function automatic logic [7:0] marker_byte(logic [MARKER_W-1:0] mk,
                                               logic [IDX_W-1:0] idx);
        logic [5:0] sh;
        sh = 6'(8 * (MARKER_LEN - 1 - int'(idx)));
        return 8'(mk >> sh);
    endfunction

endpackage

// ----- hdl/mdse_ctrl.sv -----
module mdse_ctrl
    import mdse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_st,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.latch = i_valid;
                if (i_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_st.any ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                // hold while the output register is occupied
                if (i_st.out_free) begin
                    o_cmd.load = 1'b1;
                    if (i_st.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/mdse_dp.sv -----
module mdse_dp
    import mdse_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [MARKER_W-1:0] i_cfg_data,
    input  logic [7:0]          i_in_byte,
    input  t_cmd                i_cmd,
    output t_status             o_st,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [7:0]          o_out_byte,
    output logic                o_has_byte,
    output logic                o_frame_end,
    output logic                o_last_of_run
);

    logic [MARKER_W-1:0] r_start, r_close;
    logic                r_in_payload, n_in_payload;
    logic [ML_W-1:0]     r_match_len, n_match_len;
    logic [7:0]          r_byte;
    logic [IDX_W-1:0]    r_flush_cnt, n_flush_cnt;
    logic [IDX_W-1:0]    r_idx;
    t_tail               r_tail, n_tail;
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_has, r_out_fend, r_out_last;

    logic [MARKER_W-1:0] marker, flush_marker;
    logic [IDX_W-1:0]    m;
    logic                hit, hit_first;
    logic [ML_W-1:0]     m_next;
    logic                in_flush;
    logic                load_last;

    // Evaluate the latched byte against the active marker.
    always_comb begin
        marker       = r_in_payload ? r_close : r_start;
        m            = (r_match_len >= ML_W'(MARKER_LEN)) ? '0 : IDX_W'(r_match_len);
        hit          = (r_byte == marker_byte(marker, m));
        hit_first    = (r_byte == marker_byte(marker, '0));
        n_flush_cnt  = '0;
        n_tail       = TAIL_NONE;
        n_in_payload = r_in_payload;
        if (hit) begin
            m_next = ML_W'(m) + 1'b1;
        end else begin
            if (r_in_payload) begin
                n_flush_cnt = m;
            end
            if (hit_first) begin
                m_next = ML_W'(1);
            end else begin
                m_next = '0;
                if (r_in_payload) begin
                    n_tail = TAIL_BYTE;
                end
            end
        end
        if (m_next == ML_W'(MARKER_LEN)) begin
            if (r_in_payload) begin
                n_tail       = TAIL_FEND;
                n_in_payload = 1'b0;
            end else begin
                n_in_payload = 1'b1;
            end
            m_next = '0;
        end
        n_match_len = m_next;
    end

    // Result sequencing: flushed prefix first, then the tail.
    assign flush_marker = r_close;
    assign in_flush     = (r_idx < r_flush_cnt);
    assign load_last    = in_flush ? ((r_idx == r_flush_cnt - 1'b1) && (r_tail == TAIL_NONE))
                                   : 1'b1;

    assign o_st.any      = (n_flush_cnt != '0) || (n_tail != TAIL_NONE);
    assign o_st.out_free = !r_out_valid || i_ready;
    assign o_st.last     = load_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start      <= START_RST;
            r_close      <= CLOSE_RST;
            r_in_payload <= 1'b0;
            r_match_len  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_START) begin
                    r_start <= i_cfg_data;
                end
                if (i_cfg_idx == REG_CLOSE) begin
                    r_close <= i_cfg_data;
                end
            end
            if (i_cmd.eval) begin
                r_in_payload <= n_in_payload;
                r_match_len  <= n_match_len;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_byte <= i_in_byte;
        end
        if (i_cmd.eval) begin
            r_flush_cnt <= n_flush_cnt;
            r_tail      <= n_tail;
            r_idx       <= '0;
        end
        if (i_cmd.load) begin
            r_idx      <= r_idx + 1'b1;
            r_out_last <= load_last;
            if (in_flush) begin
                r_out_byte <= marker_byte(flush_marker, r_idx);
                r_out_has  <= 1'b1;
                r_out_fend <= 1'b0;
            end else begin
                case (r_tail)
                    TAIL_BYTE: begin
                        r_out_byte <= r_byte;
                        r_out_has  <= 1'b1;
                        r_out_fend <= 1'b0;
                    end
                    TAIL_FEND: begin
                        r_out_byte <= '0;
                        r_out_has  <= 1'b0;
                        r_out_fend <= 1'b1;
                    end
                    default: begin
                        r_out_byte <= '0;
                        r_out_has  <= 1'b0;
                        r_out_fend <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_has_byte    = r_out_has;
    assign o_frame_end   = r_out_fend;
    assign o_last_of_run = r_out_last;

endmodule

// ----- hdl/marker_delimited_stream_extractor_unit.sv -----
// Channel   Direction  Handshake           Beat contents
// input     in         i_valid / o_ready   i_in_byte
// result    out        o_valid / i_ready   o_out_byte, o_has_byte, o_frame_end, o_last_of_run
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data (no back-pressure)
//
// One input beat is captured, then compared. When it yields n results (n is 1 to 8)
// they pass the output register one result per cycle while the receiver does not stall;
// that register replays a flushed close-marker prefix byte by byte.
// Reset (i_rst_n low, synchronous) loads the default markers and returns to hunting.
// A stalled result register holds; the next input beat is still captured and compared
// behind it, and its results wait until the register frees.
`include "marker_delimited_stream_extractor_unit_assert.svh"

module marker_delimited_stream_extractor_unit
    import mdse_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration writes
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [MARKER_W-1:0] i_cfg_data,
    // raw byte stream
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_in_byte,
    // deframed results
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_has_byte,
    output logic                o_frame_end,
    output logic                o_last_of_run
);

    t_cmd    cmd;
    t_status st;

    // Sequencer: capture a beat, evaluate it, then drain its results.
    mdse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    // Marker registers, match tracking and the result register.
    mdse_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_byte     (i_in_byte),
        .i_cmd         (cmd),
        .o_st          (st),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_has_byte    (o_has_byte),
        .o_frame_end   (o_frame_end),
        .o_last_of_run (o_last_of_run)
    );

    // A frame-end result carries no byte and closes its run.
    `MDSE_ASSERT_NOW(a_fend_shape, o_valid && o_frame_end, !o_has_byte && o_last_of_run && (o_out_byte == 8'h00))
    // Every result is either a payload byte or a frame end.
    `MDSE_ASSERT_NOW(a_result_kind, o_valid, o_has_byte != o_frame_end)
    // The cycle after a captured beat is spent comparing, not capturing.
    `MDSE_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready)
    // Results are only loaded while the sequencer is draining.
    `MDSE_ASSERT_NOW(a_load_excl, cmd.load, !o_ready && !cmd.eval)

endmodule

// ----- sim/marker_delimited_stream_extractor_unit_tb.sv -----
module marker_delimited_stream_extractor_unit_tb;
    import mdse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Generous cycle budget: a few hundred beats, each with pauses, flushes
    // of up to eight results and receiver stalls, plus the long hold-off.
    localparam int unsigned CYCLE_LIMIT = 600000;
    // Cycles to let pass after the last result before touching the registers.
    localparam int SETTLE_CYCLES = 20;
    // Receiver hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES = 300;

    // One deframed result beat.
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       fend;
        logic       last;
    } t_deframed;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_idx = REG_START;
    logic [MARKER_W-1:0] i_cfg_data = '0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [7:0]          i_in_byte = 8'h00;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [7:0]          o_out_byte;
    logic                o_has_byte;
    logic                o_frame_end;
    logic                o_last_of_run;

    // Raw bytes waiting to be offered, and results the deframer owes us.
    logic [7:0] raw_q[$];
    t_deframed  deframed_q[$];

    // Shadow of the deframer: registers and match state.
    logic [MARKER_W-1:0] start_mk = START_RST;
    logic [MARKER_W-1:0] close_mk = CLOSE_RST;
    logic                in_frame = 1'b0;
    int                  matched = 0;

    // Pacing controls, set by the sequence and read by the driver and monitor.
    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          mismatches = 0;
    int unsigned cycles = 0;
    t_deframed   want_beat;

    marker_delimited_stream_extractor_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_has_byte   (o_has_byte),
        .o_frame_end  (o_frame_end),
        .o_last_of_run(o_last_of_run)
    );

    always #2 i_clk = ~i_clk;

    // Byte idx of a marker, first byte in the top bits.
    function automatic logic [7:0] octet(input logic [MARKER_W-1:0] mk, input int idx);
        return 8'(mk >> (8 * (MARKER_LEN - 1 - idx)));
    endfunction

    // Advance the shadow deframer by one raw byte and queue what it owes.
    task automatic deframe_byte(input logic [7:0] b);
        logic [MARKER_W-1:0] mk;
        t_deframed           run[MARKER_LEN + 1];
        int                  m;
        int                  n;
        int                  k;
        mk = in_frame ? close_mk : start_mk;
        m = (matched >= MARKER_LEN) ? 0 : matched;
        n = 0;
        if (b == octet(mk, m)) begin
            m++;
        end else begin
            // Flush the held prefix straight out of the marker register.
            if (in_frame) begin
                for (k = 0; k < m; k++) begin
                    run[n] = '{data: octet(mk, k), has: 1'b1, fend: 1'b0, last: 1'b0};
                    n++;
                end
            end
            m = 0;
            // Restart looks at the first marker byte only.
            if (b == octet(mk, 0)) begin
                m = 1;
            end else if (in_frame) begin
                run[n] = '{data: b, has: 1'b1, fend: 1'b0, last: 1'b0};
                n++;
            end
        end
        if (m == MARKER_LEN) begin
            if (in_frame) begin
                run[n] = '{data: 8'h00, has: 1'b0, fend: 1'b1, last: 1'b0};
                n++;
                in_frame = 1'b0;
            end else begin
                in_frame = 1'b1;
            end
            m = 0;
        end
        matched = m;
        for (k = 0; k < n; k++) begin
            if (k == n - 1) begin
                run[k].last = 1'b1;
            end
            deframed_q.push_back(run[k]);
        end
    endtask

    // Sender pause after a beat: mostly none, some short, a few long.
    function automatic int tx_pause();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return 0;
        end
        if (r < 9) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Receiver stall length: mostly short, now and then long.
    function automatic int rx_stall();
        if ($urandom_range(0, 6) != 0) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Driver: offer raw bytes from the queue, hold them until taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            i_in_byte <= 8'h00;
            tx_gap    <= 0;
        end else begin
            // Predict on the beat that is taken at this edge.
            if (i_valid && o_ready) begin
                deframe_byte(i_in_byte);
            end
            // Only move on once the current beat is gone.
            if (!i_valid || o_ready) begin
                if (tx_gap != 0) begin
                    i_valid <= 1'b0;
                    tx_gap  <= tx_gap - 1;
                end else if (raw_q.size() != 0) begin
                    i_valid   <= 1'b1;
                    i_in_byte <= raw_q.pop_front();
                    tx_gap    <= tx_calm ? 0 : tx_pause();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off: fire once on each rising request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_req && !hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= 1'b1;
        end else begin
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end
            if (!hold_req) begin
                hold_seen <= 1'b0;
            end
        end
    end

    // Monitor: check each result beat against the oldest expectation and
    // throttle the receive side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_gap  <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (deframed_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: byte %h has %b fend %b last %b",
                                 o_out_byte, o_has_byte, o_frame_end, o_last_of_run);
                    end
                end else begin
                    want_beat = deframed_q.pop_front();
                    if (o_out_byte !== want_beat.data || o_has_byte !== want_beat.has ||
                        o_frame_end !== want_beat.fend || o_last_of_run !== want_beat.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch: expected byte %h has %b fend %b last %b, got byte %h has %b fend %b last %b",
                                     want_beat.data, want_beat.has, want_beat.fend,
                                     want_beat.last, o_out_byte, o_has_byte, o_frame_end,
                                     o_last_of_run);
                        end
                    end
                end
            end
            if (hold_left != 0) begin
                i_ready <= 1'b0;
            end else if (rx_gap != 0) begin
                i_ready <= 1'b0;
                rx_gap  <= rx_gap - 1;
            end else if (!rx_calm && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                rx_gap  <= rx_stall() - 1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Write one marker register; keep the shadow copy in step.
    task automatic write_reg(input logic idx, input logic [MARKER_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == REG_START) begin
            start_mk = val;
        end else begin
            close_mk = val;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Queue the first len bytes of a marker.
    task automatic queue_marker(input logic [MARKER_W-1:0] mk, input int len);
        int k;
        for (k = 0; k < len; k++) begin
            raw_q.push_back(octet(mk, k));
        end
    endtask

    // Queue payload: random bytes salted with close-marker prefixes and
    // restarts on the first close byte.
    task automatic queue_payload(input int n);
        int k;
        int r;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                raw_q.push_back(8'($urandom));
            end else if (r < 7) begin
                raw_q.push_back(octet(close_mk, 0));
            end else begin
                queue_marker(close_mk, $urandom_range(1, MARKER_LEN - 1));
            end
        end
    endtask

    // Queue about budget bytes: mostly whole frames, the rest broken
    // frames, broken start markers and line noise.
    task automatic queue_frames(input int budget);
        int base;
        int r;
        int k;
        base = raw_q.size();
        while (raw_q.size() - base < budget) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                for (k = $urandom_range(0, 2); k > 0; k--) begin
                    raw_q.push_back(8'($urandom));
                end
                queue_marker(start_mk, MARKER_LEN);
                queue_payload($urandom_range(0, 8));
                queue_marker(close_mk, MARKER_LEN);
            end else if (r == 7) begin
                queue_marker(start_mk, $urandom_range(1, MARKER_LEN - 1));
                raw_q.push_back(8'($urandom));
            end else if (r == 8) begin
                // Frame cut short: partial close, then a random byte flushes it.
                queue_marker(start_mk, MARKER_LEN);
                queue_payload($urandom_range(0, 4));
                queue_marker(close_mk, $urandom_range(1, MARKER_LEN - 1));
                raw_q.push_back(8'($urandom));
                queue_marker(close_mk, MARKER_LEN);
            end else begin
                for (k = $urandom_range(1, 4); k > 0; k--) begin
                    raw_q.push_back(8'($urandom));
                end
            end
        end
    endtask

    // Wait until every byte is taken and every result has come, then let
    // the block's pipeline run dry.
    task automatic settle();
        while (raw_q.size() != 0 || i_valid || deframed_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: noise while hunting, start marker, byte extremes, a
        // seven-byte held prefix broken by a restart, then the rest of the
        // close marker for a frame end.
        @(negedge i_clk);
        raw_q.push_back(8'hFF);
        raw_q.push_back(8'h00);
        queue_marker(start_mk, MARKER_LEN);
        raw_q.push_back(8'h00);
        raw_q.push_back(8'hFF);
        queue_marker(close_mk, MARKER_LEN - 1);
        raw_q.push_back(octet(close_mk, 0));
        for (int k = 1; k < MARKER_LEN; k++) begin
            raw_q.push_back(octet(close_mk, k));
        end
        settle();

        // Extremes: all-zero start marker, all-ones close marker.
        write_reg(REG_START, '0);
        write_reg(REG_CLOSE, '1);
        @(negedge i_clk);
        queue_frames(45);
        settle();

        // Random markers, no idling on either side. End inside a frame with
        // a close prefix held back.
        @(posedge i_clk);
        tx_calm <= 1'b1;
        rx_calm <= 1'b1;
        write_reg(REG_START, {$urandom, $urandom});
        write_reg(REG_CLOSE, {$urandom, $urandom});
        @(negedge i_clk);
        queue_frames(45);
        queue_marker(start_mk, MARKER_LEN);
        queue_marker(close_mk, 3);
        settle();

        // Swap the close marker under a held prefix; the flush must come
        // from the new value. End partway into a start marker.
        @(posedge i_clk);
        tx_calm <= 1'b0;
        rx_calm <= 1'b0;
        write_reg(REG_CLOSE, {start_mk[MARKER_W-1:8], ~start_mk[7:0]});
        @(negedge i_clk);
        raw_q.push_back(~octet(close_mk, 0));
        queue_frames(45);
        queue_marker(start_mk, 2);
        settle();

        // Back to the reset markers, rewritten mid start-match. Hold the
        // receiver off while the sender keeps offering, so the block backs up.
        write_reg(REG_START, START_RST);
        write_reg(REG_CLOSE, CLOSE_RST);
        @(posedge i_clk);
        tx_calm  <= 1'b1;
        hold_req <= 1'b1;
        @(negedge i_clk);
        queue_frames(45);
        settle();

        if (mismatches == 0 && deframed_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
